// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the allocator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked property that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/cpba_pkg.sv =====
// ---------------------------------------------------------------------------
// cpba_pkg
// shared constants and types of the contiguous page bitmap allocator
// ---------------------------------------------------------------------------
package cpba_pkg;

   // page geometry
   localparam int TOTAL_PAGES = 1024;          // multiple of WORD_W
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_W      = 22;
   localparam int SIZE_W      = 23;
   localparam int STATUS_W    = 2;

   // bitmap storage: one word of WORD_W page bits per ram row
   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int WORDS       = TOTAL_PAGES / WORD_W;
   localparam int WORD_AW     = (WORDS > 1) ? $clog2(WORDS) : 1;

   // page index and page count widths
   localparam int PAGE_W      = $clog2(TOTAL_PAGES);
   localparam int N_W         = SIZE_W - PAGE_SHIFT + 1;
   localparam int CMP_W       = ((PAGE_W + 1 > N_W) ? PAGE_W + 1 : N_W) + 2;

   // scan digit
   localparam int DIGIT_W     = 4;
   localparam int DIGITS      = WORD_W / DIGIT_W;
   localparam int DIG_CW      = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   // request codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

   // controls from the sequencer to the scan unit
   typedef struct packed {
      logic clr;
      logic load;
      logic step;
   } scan_ctl_type;

   // scan unit result
   typedef struct packed {
      logic              found;
      logic [PAGE_W-1:0] first;
   } scan_stat_type;

endpackage

// ===== rtl/contiguous_page_bitmap_allocator.sv =====
// ---------------------------------------------------------------------------
// contiguous_page_bitmap_allocator
// first-fit allocator of contiguous 4096-byte pages over a used-page bitmap
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result word per
// request comes back on the rsp_ ports with rsp_valid high for exactly one
// cycle, and the receiver cannot stall it. The bitmap sits in a ram of
// 32-bit rows; each row has a valid flip-flop so reset frees every page at
// once with no clearing pass. A zero-size request, an oversize allocate and a
// free past the end are answered in the next cycle. An allocate scans 4 pages
// per cycle in its digit steps: per bitmap row it reads the row, loads it and
// steps through its 8 digits, leaving early once the run is found, else it
// checks; then it reads and writes each row the run touches and answers. A
// free reads and writes each row it touches, then answers. The ram's single
// write port and single read port and the 4-bit scan digit set this pace.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module contiguous_page_bitmap_allocator import cpba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_page_address
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN_RD  = 7'b0000010,
      S_SCAN_LD  = 7'b0000100,
      S_SCAN_DIG = 7'b0001000,
      S_SCAN_CHK = 7'b0010000,
      S_UPD_RD   = 7'b0100000,
      S_UPD_WR   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic                  op_ff, op_in;
   logic [N_W-1:0]        n_ff, n_in;
   logic [PAGE_W-1:0]     lo_ff, lo_in;
   logic [PAGE_W-1:0]     hi_ff, hi_in;
   logic [WORD_AW-1:0]    word_ff, word_in;
   logic [DIG_CW-1:0]     dig_ff, dig_in;
   logic                  valid_ff [WORDS];
   logic                  rd_valid_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;

   logic                  rd_en;
   logic                  wr_en;
   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     wr_data;
   logic [WORD_W-1:0]     old_word;
   logic [WORD_W-1:0]     mask;
   logic [BIT_W-1:0]      lo_bit;
   logic [BIT_W-1:0]      hi_bit;
   logic [WORD_AW-1:0]    lo_word;
   logic [WORD_AW-1:0]    hi_word;
   logic [N_W-1:0]        req_pages;
   logic [ADDR_W-PAGE_SHIFT-1:0] req_page;
   logic [CMP_W-1:0]      free_end;
   logic [CMP_W-1:0]      mark_end;
   scan_ctl_type          scan_ctl;
   scan_stat_type         scan_stat;

   // bitmap rows
   cpba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (word_ff),
      .rd_data (rd_data)
   );

   // a row never written since reset reads as all free
   assign old_word = rd_valid_ff ? rd_data : '0;

   // run finder
   cpba_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .word      (old_word),
      .base_page (PAGE_W'(word_ff) << BIT_W),
      .pages_n   (n_ff),
      .stat      (scan_stat)
   );

   // request decode: page count rounded up, page of the address
   assign req_pages = N_W'(req_size_bytes >> PAGE_SHIFT)
                    + N_W'(|req_size_bytes[PAGE_SHIFT-1:0]);
   assign req_page  = req_address[ADDR_W-1:PAGE_SHIFT];
   assign free_end  = CMP_W'(req_page) + CMP_W'(req_pages);
   assign mark_end  = CMP_W'(scan_stat.first) + CMP_W'(n_ff) - CMP_W'(1);

   // row mask of the pages in range
   assign lo_word = WORD_AW'(lo_ff >> BIT_W);
   assign hi_word = WORD_AW'(hi_ff >> BIT_W);
   assign lo_bit  = (word_ff == lo_word) ? lo_ff[BIT_W-1:0] : '0;
   assign hi_bit  = (word_ff == hi_word) ? hi_ff[BIT_W-1:0] : '1;
   assign mask    = ({WORD_W{1'b1}} << lo_bit)
                  & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
   assign wr_data = (op_ff == OP_FREE) ? (old_word & ~mask) : (old_word | mask);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      n_in          = n_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      word_in       = word_ff;
      dig_in        = dig_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      scan_ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_op;
               n_in  = req_pages;
               if (req_pages == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BAD;
                  rsp_addr_in   = '0;
               end else if (req_op == OP_ALLOC) begin
                  if (CMP_W'(req_pages) > CMP_W'(TOTAL_PAGES)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOFIT;
                     rsp_addr_in   = '0;
                  end else begin
                     scan_ctl.clr = 1'b1;
                     word_in      = '0;
                     state_in     = S_SCAN_RD;
                  end
               end else begin
                  if (free_end > CMP_W'(TOTAL_PAGES)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BAD;
                     rsp_addr_in   = '0;
                  end else begin
                     lo_in    = PAGE_W'(req_page);
                     hi_in    = PAGE_W'(free_end - CMP_W'(1));
                     word_in  = WORD_AW'(PAGE_W'(req_page) >> BIT_W);
                     state_in = S_UPD_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = S_SCAN_LD;
         end
         S_SCAN_LD: begin
            scan_ctl.load = 1'b1;
            dig_in        = '0;
            state_in      = S_SCAN_DIG;
         end
         S_SCAN_DIG: begin
            if (scan_stat.found) begin
               lo_in    = scan_stat.first;
               hi_in    = PAGE_W'(mark_end);
               word_in  = WORD_AW'(scan_stat.first >> BIT_W);
               state_in = S_UPD_RD;
            end else begin
               scan_ctl.step = 1'b1;
               dig_in        = dig_ff + DIG_CW'(1);
               if (dig_ff == DIG_CW'(DIGITS - 1)) begin
                  state_in = S_SCAN_CHK;
               end
            end
         end
         S_SCAN_CHK: begin
            if (scan_stat.found) begin
               lo_in    = scan_stat.first;
               hi_in    = PAGE_W'(mark_end);
               word_in  = WORD_AW'(scan_stat.first >> BIT_W);
               state_in = S_UPD_RD;
            end else if (word_ff == WORD_AW'(WORDS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOFIT;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else begin
               word_in  = word_ff + WORD_AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_UPD_RD: begin
            rd_en    = 1'b1;
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            wr_en = 1'b1;
            if (word_ff == hi_word) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_addr_in   = (op_ff == OP_FREE) ? '0
                             : (ADDR_W'(lo_ff) << PAGE_SHIFT);
               state_in      = S_IDLE;
            end else begin
               word_in  = word_ff + WORD_AW'(1);
               state_in = S_UPD_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // row valid bits: set on the first write of a row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[word_ff] <= 1'b1;
      end
   end

   // valid bit follows the ram read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[word_ff];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      n_ff          <= n_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      word_ff       <= word_in;
      dig_ff        <= dig_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_addr_ff;

   // a result word only appears once the sequencer is back in idle
   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_valid |-> !busy)

   // a zero-size request is rejected in the next cycle
   `ASSERT_CLK(a_zero_size, clock, reset,
      start && !busy && req_size_bytes == '0 |=> rsp_valid && rsp_status == ST_BAD)

   // failures never report an address
   `ASSERT_CLK(a_fail_addr, clock, reset,
      rsp_valid && rsp_status != ST_DONE |-> rsp_page_address == '0)

endmodule

// ===== rtl/cpba_ram.sv =====
// ---------------------------------------------------------------------------
// cpba_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module cpba_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cpba_scan.sv =====
// ---------------------------------------------------------------------------
// cpba_scan
// digit-serial first-fit run finder: shifts a bitmap word out a digit per
// cycle while stepped and tracks the current run of free pages
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpba_scan import cpba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  scan_ctl_type        ctl,
   input  logic [WORD_W-1:0]   word,
   input  logic [PAGE_W-1:0]   base_page,
   input  logic [N_W-1:0]      pages_n,
   output scan_stat_type       stat
);

   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [PAGE_W-1:0] pos_ff, pos_in;
   logic [N_W-1:0]    run_ff, run_in;
   logic [PAGE_W-1:0] start_ff, start_in;
   logic              found_ff, found_in;
   logic [PAGE_W-1:0] first_ff, first_in;

   // next state of the run tracker
   always_comb begin
      shift_in = shift_ff;
      pos_in   = pos_ff;
      run_in   = run_ff;
      start_in = start_ff;
      found_in = found_ff;
      first_in = first_ff;
      if (ctl.clr) begin
         run_in   = '0;
         found_in = 1'b0;
      end else if (ctl.load) begin
         shift_in = word;
         pos_in   = base_page;
      end else if (ctl.step) begin
         shift_in = shift_ff >> DIGIT_W;
         pos_in   = pos_ff + PAGE_W'(DIGIT_W);
         // one digit of pages, lowest page first
         for (int i = 0; i < DIGIT_W; i++) begin
            if (!found_in) begin
               if (shift_ff[i]) begin
                  run_in = '0;
               end else begin
                  if (run_in == '0) begin
                     start_in = pos_ff + PAGE_W'(i);
                  end
                  run_in = run_in + N_W'(1);
                  if (run_in == pages_n) begin
                     found_in = 1'b1;
                     first_in = start_in;
                  end
               end
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         run_ff   <= '0;
      end else begin
         found_ff <= found_in;
         run_ff   <= run_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      pos_ff   <= pos_in;
      start_ff <= start_in;
      first_ff <= first_in;
   end

   assign stat.found = found_ff;
   assign stat.first = first_ff;

   // a found run stays put until the next request clears the tracker
   `ASSERT_CLK(a_found_holds, clock, reset,
      found_ff && !ctl.clr |=> found_ff && $stable(first_ff))

endmodule

// ===== verif/cpba_checker.sv =====
// ----------------------------------------------------------------------------
// cpba_checker
// Watches the request and response words of the page allocator, keeps its own
// used-page bitmap, predicts the response of every accepted request and
// compares each response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cpba_checker import cpba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_op,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [ADDR_W-1:0]   rsp_page_address,
   output int                  fail_count,
   output int                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   page_address;
   } alloc_outcome_type;

   // mirror of the used-page bitmap
   logic page_used [TOTAL_PAGES];

   // responses still owed by the block, oldest first
   alloc_outcome_type pending_outcomes [$];

   // apply one request to the mirror bitmap and return its response word
   function automatic alloc_outcome_type apply_request(input logic op,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [SIZE_W-1:0] size);
      alloc_outcome_type outcome;
      int pages;
      int run;
      int first_page;
      int page;
      bit found;
      outcome = '{status: ST_DONE, page_address: '0};
      pages = int'(size[SIZE_W-1:PAGE_SHIFT]) + ((size[PAGE_SHIFT-1:0] != 0) ? 1 : 0);
      found = 1'b0;
      run = 0;
      first_page = 0;
      if (op == OP_ALLOC) begin
         if (pages == 0) begin
            outcome.status = ST_BAD;
         end else if (pages > TOTAL_PAGES) begin
            outcome.status = ST_NOFIT;
         end else begin
            // first fit: lowest run of free pages that is long enough
            for (int p = 0; p < TOTAL_PAGES && !found; p++) begin
               if (page_used[p]) begin
                  run = 0;
               end else begin
                  if (run == 0) first_page = p;
                  run++;
                  if (run == pages) found = 1'b1;
               end
            end
            if (!found) begin
               outcome.status = ST_NOFIT;
            end else begin
               for (int p = first_page; p < first_page + pages; p++) page_used[p] = 1'b1;
               outcome.page_address = ADDR_W'(first_page << PAGE_SHIFT);
            end
         end
      end else begin
         page = int'(addr[ADDR_W-1:PAGE_SHIFT]);
         // zero size or range running off the end clears nothing
         if (pages == 0 || page + pages > TOTAL_PAGES) begin
            outcome.status = ST_BAD;
         end else begin
            for (int p = page; p < page + pages; p++) page_used[p] = 1'b0;
         end
      end
      return outcome;
   endfunction

   // compare response words, then predict for the request word taken now
   always @(posedge clock) begin
      alloc_outcome_type seen;
      alloc_outcome_type wanted;
      if (reset) begin
         pending_outcomes.delete();
         foreach (page_used[p]) page_used[p] = 1'b0;
         fail_count <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            seen = '{status: rsp_status, page_address: rsp_page_address};
            if (pending_outcomes.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response with none expected: status %0d address 0x%06h",
                           $realtime, seen.status, seen.page_address);
               fail_count <= fail_count + 1;
            end else begin
               wanted = pending_outcomes.pop_front();
               if (seen.status !== wanted.status ||
                   seen.page_address !== wanted.page_address) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch: status exp %0d got %0d, ",
                               "page_address exp 0x%06h got 0x%06h"},
                              $realtime, wanted.status, seen.status,
                              wanted.page_address, seen.page_address);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            pending_outcomes.push_back(apply_request(req_op, req_address, req_size_bytes));
         outstanding <= pending_outcomes.size();
      end
   end

endmodule

// ===== verif/contiguous_page_bitmap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_tb
// Drives directed corner requests and then a long random mix of allocations,
// frees of granted runs and malformed requests into the page allocator, with
// random gaps; the checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_tb;
   import cpba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 1500;
   localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_op = OP_ALLOC;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [SIZE_W-1:0]   req_size_bytes = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_page_address;
   int                  fail_count;
   int                  outstanding;

   // request words in flight, and runs the block has granted
   typedef struct {
      logic              op;
      logic [SIZE_W-1:0] size;
   } sent_request_type;

   typedef struct {
      logic [PAGE_W-1:0] page;
      logic [SIZE_W-1:0] size;
   } granted_run_type;

   sent_request_type sent_requests [$];
   granted_run_type  granted_runs [$];

   contiguous_page_bitmap_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_address      (req_address),
      .req_size_bytes   (req_size_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address)
   );

   cpba_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_address      (req_address),
      .req_size_bytes   (req_size_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // remember granted runs so that later frees can return them
   always @(posedge clock) begin
      sent_request_type req;
      if (!reset && rsp_valid && sent_requests.size() != 0) begin
         req = sent_requests.pop_front();
         if (req.op == OP_ALLOC && rsp_status == ST_DONE)
            granted_runs.push_back('{page: rsp_page_address[ADDR_W-1:PAGE_SHIFT],
                                     size: req.size});
      end
   end

   // present one request word and hold it until the block takes it
   task automatic issue(input logic op, input logic [ADDR_W-1:0] addr,
                        input logic [SIZE_W-1:0] size);
      start <= 1'b1;
      req_op <= op;
      req_address <= addr;
      req_size_bytes <= size;
      do @(posedge clock); while (busy);
      sent_requests.push_back('{op: op, size: size});
   endtask

   // random gap after a request word
   task automatic maybe_idle(input bit quiet);
      if (!quiet && $urandom_range(0, 99) < 24) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // hold off until every response has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // byte count that rounds to the given number of pages
   function automatic logic [SIZE_W-1:0] bytes_for(input int pages);
      return SIZE_W'((pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES));
   endfunction

   // mostly small allocations, a few large ones
   function automatic logic [SIZE_W-1:0] pick_alloc_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return bytes_for($urandom_range(1, 8));
      if (r < 90) return bytes_for($urandom_range(9, 64));
      if (r < 98) return bytes_for($urandom_range(65, 512));
      return bytes_for($urandom_range(513, TOTAL_PAGES));
   endfunction

   initial begin
      #40ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int r;
      int idx;
      bit quiet;
      granted_run_type run;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      issue(OP_ALLOC, '0, '0);                      // zero-size allocate
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'd1);
      maybe_idle(0);
      issue(OP_ALLOC, 22'h3FFFFF, 23'd4096);
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'd4097);
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'h400000);              // whole bitmap, does not fit now
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'h7FFFFF);              // larger than the bitmap
      maybe_idle(0);
      issue(OP_FREE, 22'h001000, '0);               // zero-size free
      maybe_idle(0);
      issue(OP_FREE, 22'h3FFFFF, 23'd4096);         // last page exactly
      maybe_idle(0);
      issue(OP_FREE, 22'h3FF000, 23'd8192);         // one page past the end
      maybe_idle(0);
      issue(OP_FREE, 22'h3FFFFF, 23'h7FFFFF);
      maybe_idle(0);
      issue(OP_FREE, 22'h001FFF, 23'd1);            // low address bits ignored
      maybe_idle(0);
      issue(OP_FREE, 22'h100000, 23'd4096);         // page already free
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'd4096);
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'd8192);
      maybe_idle(0);
      issue(OP_FREE, '0, 23'h400000);               // clear everything
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'h400000);              // fill everything
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'd1);                   // full bitmap
      maybe_idle(0);
      issue(OP_FREE, 22'h3FF000, 23'd4096);
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'd8192);                // trailing free run too short
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'd4096);
      maybe_idle(0);
      issue(OP_FREE, 22'h200000, 23'h200000);
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'h200001);
      maybe_idle(0);
      issue(OP_ALLOC, '0, 23'h200000);
      maybe_idle(0);
      issue(OP_FREE, '0, 23'h400000);
      drain();

      // random mix: allocations, frees of granted runs, stray and malformed words
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         quiet = (i >= 600 && i < 900);
         r = $urandom_range(0, 99);
         if (r < 50) begin
            issue(OP_ALLOC, ADDR_W'($urandom), pick_alloc_size());
         end else if (r < 85 && granted_runs.size() != 0) begin
            idx = $urandom_range(0, granted_runs.size() - 1);
            run = granted_runs[idx];
            granted_runs.delete(idx);
            issue(OP_FREE, {run.page, PAGE_SHIFT'($urandom)}, run.size);
         end else if (r < 95) begin
            issue(OP_FREE, {PAGE_W'($urandom), PAGE_SHIFT'($urandom)},
                  bytes_for($urandom_range(1, 32)));
         end else begin
            case ($urandom_range(0, 2))
               0: issue(1'($urandom), ADDR_W'($urandom), '0);
               1: issue(1'($urandom), ADDR_W'($urandom), SIZE_W'($urandom));
               default: issue(1'($urandom), ADDR_W'($urandom),
                              SIZE_W'($urandom_range(23'h400001, 23'h7FFFFF)));
            endcase
         end
         if (i == 400 || i == 1100) drain();
         else maybe_idle(quiet);
      end

      // let the last responses arrive, then give the verdict
      drain();
      repeat (450) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
